// ----- rtl/core/irm_pkg.sv -----
package irm_pkg;

  // command codes on the func field
  localparam logic [1:0] FUNC_NONE  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // transaction status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BUS_BUSY  = 2'd1;
  localparam logic [1:0] STAT_ADDR_NACK = 2'd2;
  localparam logic [1:0] STAT_DATA_NACK = 2'd3;

  // reset value of the quarter-bit phase length
  localparam logic [15:0] PHASE_TICKS_RST = 16'd8;

  // decoded command kind handed from the front to the sequencer
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_READ
  } cmd_e;

  // one input item as seen on the ports
  typedef struct packed {
    logic [1:0] func;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] wr_data;
    logic       sda_in;
  } in_item_t;

  // one result item as seen on the ports
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       data_request;
    logic       rd_valid;
    logic [7:0] rd_data;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } out_item_t;

  // classified item held in the front queue
  typedef struct packed {
    cmd_e       cmd;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] wr_data;
    logic       sda_in;
  } front_item_t;

endpackage

// ----- rtl/core/irm_front.sv -----
module irm_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  irm_pkg::in_item_t    item_i,
  output logic                 valid_o,
  input  logic                 take_i,
  output irm_pkg::front_item_t item_o
);

  irm_pkg::front_item_t cls;
  irm_pkg::front_item_t mem_q [2];
  logic                 wr_ptr_q, wr_ptr_d;
  logic                 rd_ptr_q, rd_ptr_d;
  logic [1:0]           cnt_q, cnt_d;
  logic                 push_ok;
  logic                 pop_ok;

  // classify the command code
  always_comb begin
    cls.dev_addr   = item_i.dev_addr;
    cls.reg_addr   = item_i.reg_addr;
    cls.byte_count = item_i.byte_count;
    cls.wr_data    = item_i.wr_data;
    cls.sda_in     = item_i.sda_in;
    unique case (item_i.func)
      irm_pkg::FUNC_WRITE: cls.cmd = irm_pkg::CMD_WRITE;
      irm_pkg::FUNC_READ:  cls.cmd = irm_pkg::CMD_READ;
      default:             cls.cmd = irm_pkg::CMD_NONE;
    endcase
  end

  // queue control
  assign full    = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign push_ok = push && !full;
  assign pop_ok  = take_i && valid_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_ok;
    rd_ptr_d = rd_ptr_q ^ pop_ok;
    cnt_d    = cnt_q + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // item storage
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ----- rtl/core/irm_result_q.sv -----
module irm_result_q (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               ready_o,
  input  irm_pkg::out_item_t item_i,
  output logic               empty,
  input  logic               pop,
  output irm_pkg::out_item_t item_o
);

  irm_pkg::out_item_t mem_q [2];
  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;
  logic [1:0]         cnt_q, cnt_d;
  logic               push_ok;
  logic               pop_ok;

  // queue control
  assign ready_o = (cnt_q != 2'd2);
  assign empty   = (cnt_q == 2'd0);
  assign push_ok = push_i && ready_o;
  assign pop_ok  = pop && !empty;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_ok;
    rd_ptr_d = rd_ptr_q ^ pop_ok;
    cnt_d    = cnt_q + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // item storage
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- rtl/core/irm_seq.sv -----
module irm_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid_i,
  input  irm_pkg::front_item_t in_item_i,
  output logic                 in_take_o,
  input  logic                 out_ready_i,
  output logic                 out_push_o,
  output irm_pkg::out_item_t   out_item_o
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_S0,
    PH_S1,
    PH_S2,
    PH_RS0,
    PH_RS1,
    PH_RS2,
    PH_T0,
    PH_T1,
    PH_T2,
    PH_FETCH,
    PH_BYTE
  } phase_e;

  typedef enum logic [2:0] {
    BK_ADDRW,
    BK_REG,
    BK_DATA,
    BK_ADDRR,
    BK_RECV
  } kind_e;

  phase_e      phase_q, phase_d;
  kind_e       kind_q, kind_d;
  logic [1:0]  qtr_q, qtr_d;
  logic [15:0] pc_q, pc_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  left_q, left_d;
  logic [6:0]  dev_q, dev_d;
  logic [7:0]  reg_q, reg_d;
  logic        rmode_q, rmode_d;
  logic [1:0]  stat_q, stat_d;
  logic [15:0] ticks_q;

  logic [15:0] pt_eff;
  logic [16:0] pc_inc;
  logic        phase_more;
  logic [7:0]  left_dec;
  logic        take;
  logic        req;
  logic        done;
  logic        rv;
  logic        scl;
  logic        sda;

  assign take       = in_valid_i && out_ready_i;
  assign in_take_o  = take;
  assign out_push_o = take;
  assign pt_eff     = (ticks_q == 16'd0) ? 16'd1 : ticks_q;
  assign pc_inc     = {1'b0, pc_q} + 17'd1;
  assign phase_more = (pc_inc < {1'b0, pt_eff});
  assign left_dec   = left_q - 8'd1;

  // next state for one tick
  always_comb begin
    phase_d = phase_q;
    kind_d  = kind_q;
    qtr_d   = qtr_q;
    pc_d    = pc_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    left_d  = left_q;
    dev_d   = dev_q;
    reg_d   = reg_q;
    rmode_d = rmode_q;
    stat_d  = stat_q;
    req     = 1'b0;
    done    = 1'b0;
    rv      = 1'b0;
    if (phase_q == PH_IDLE) begin
      if (in_item_i.cmd == irm_pkg::CMD_WRITE || in_item_i.cmd == irm_pkg::CMD_READ) begin
        dev_d   = in_item_i.dev_addr;
        reg_d   = in_item_i.reg_addr;
        left_d  = in_item_i.byte_count;
        rmode_d = (in_item_i.cmd == irm_pkg::CMD_READ);
        stat_d  = irm_pkg::STAT_OK;
        pc_d    = 16'd0;
        phase_d = PH_S0;
      end
    end else if (phase_q == PH_FETCH) begin
      // latch the requested write byte
      phase_d = PH_BYTE;
      kind_d  = BK_DATA;
      qtr_d   = 2'd0;
      bit_d   = 4'd0;
      shift_d = in_item_i.wr_data;
      pc_d    = 16'd0;
    end else if (phase_more) begin
      pc_d = pc_inc[15:0];
    end else begin
      pc_d = 16'd0;
      unique case (phase_q)
        PH_S0: begin
          if (!in_item_i.sda_in) begin
            stat_d  = irm_pkg::STAT_BUS_BUSY;
            done    = 1'b1;
            phase_d = PH_IDLE;
          end else begin
            phase_d = PH_S1;
          end
        end
        PH_S1: begin
          if (in_item_i.sda_in) begin
            stat_d  = irm_pkg::STAT_BUS_BUSY;
            done    = 1'b1;
            phase_d = PH_IDLE;
          end else begin
            phase_d = PH_S2;
          end
        end
        PH_S2: begin
          phase_d = PH_BYTE;
          kind_d  = BK_ADDRW;
          qtr_d   = 2'd0;
          bit_d   = 4'd0;
          shift_d = {dev_q, 1'b0};
        end
        PH_RS0: phase_d = PH_RS1;
        PH_RS1: phase_d = PH_RS2;
        PH_RS2: begin
          phase_d = PH_BYTE;
          kind_d  = BK_ADDRR;
          qtr_d   = 2'd0;
          bit_d   = 4'd0;
          shift_d = {dev_q, 1'b1};
        end
        PH_T0: phase_d = PH_T1;
        PH_T1: phase_d = PH_T2;
        PH_T2: begin
          done    = 1'b1;
          phase_d = PH_IDLE;
        end
        PH_BYTE: begin
          if (qtr_q < 2'd2) begin
            qtr_d = qtr_q + 2'd1;
          end else if (qtr_q == 2'd2) begin
            // sample point of the bit
            if (kind_q == BK_RECV) begin
              if (bit_q < 4'd8) begin
                shift_d = {shift_q[6:0], in_item_i.sda_in};
                rv      = (bit_q == 4'd7);
              end
            end else if (bit_q == 4'd8) begin
              shift_d = {7'd0, in_item_i.sda_in};
            end
            qtr_d = 2'd3;
          end else begin
            bit_d = bit_q + 4'd1;
            if (bit_q < 4'd8) begin
              qtr_d = 2'd0;
            end else begin
              // end of byte including the ack bit
              unique case (kind_q)
                BK_ADDRW: begin
                  if (shift_q[0]) begin
                    stat_d  = irm_pkg::STAT_ADDR_NACK;
                    phase_d = PH_T0;
                  end else begin
                    kind_d  = BK_REG;
                    qtr_d   = 2'd0;
                    bit_d   = 4'd0;
                    shift_d = reg_q;
                  end
                end
                BK_REG: begin
                  if (rmode_q) begin
                    phase_d = PH_RS0;
                  end else if (left_q != 8'd0) begin
                    phase_d = PH_FETCH;
                    req     = 1'b1;
                  end else begin
                    phase_d = PH_T0;
                  end
                end
                BK_DATA: begin
                  if (shift_q[0]) begin
                    stat_d  = irm_pkg::STAT_DATA_NACK;
                    phase_d = PH_T0;
                  end else begin
                    left_d = left_dec;
                    if (left_dec != 8'd0) begin
                      phase_d = PH_FETCH;
                      req     = 1'b1;
                    end else begin
                      phase_d = PH_T0;
                    end
                  end
                end
                BK_ADDRR: begin
                  if (left_q != 8'd0) begin
                    kind_d  = BK_RECV;
                    qtr_d   = 2'd0;
                    bit_d   = 4'd0;
                    shift_d = 8'd0;
                  end else begin
                    phase_d = PH_T0;
                  end
                end
                default: begin
                  left_d = left_dec;
                  if (left_dec != 8'd0) begin
                    qtr_d   = 2'd0;
                    bit_d   = 4'd0;
                    shift_d = 8'd0;
                  end else begin
                    phase_d = PH_T0;
                  end
                end
              endcase
            end
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  // line drive from the new state
  always_comb begin
    scl = 1'b1;
    sda = 1'b1;
    unique case (phase_d)
      PH_S1, PH_RS1, PH_T1: begin
        scl = 1'b1;
        sda = 1'b0;
      end
      PH_S2, PH_RS2, PH_T0: begin
        scl = 1'b0;
        sda = 1'b0;
      end
      PH_FETCH: begin
        scl = 1'b0;
        sda = 1'b1;
      end
      PH_BYTE: begin
        scl = (qtr_d == 2'd1) || (qtr_d == 2'd2);
        if (kind_d == BK_RECV) begin
          sda = (bit_d < 4'd8) ? 1'b1 : (left_d == 8'd1);
        end else begin
          sda = (bit_d < 4'd8) ? shift_d[~bit_d[2:0]] : 1'b1;
        end
      end
      default: begin
        scl = 1'b1;
        sda = 1'b1;
      end
    endcase
  end

  // result item
  always_comb begin
    out_item_o.scl_out      = scl;
    out_item_o.sda_out      = sda;
    out_item_o.data_request = req;
    out_item_o.rd_valid     = rv;
    out_item_o.rd_data      = rv ? shift_d : 8'd0;
    out_item_o.busy_res     = (phase_d != PH_IDLE);
    out_item_o.done_res     = done;
    out_item_o.status       = stat_d;
  end

  // sequencer state and phase length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      kind_q  <= BK_ADDRW;
      qtr_q   <= 2'd0;
      pc_q    <= 16'd0;
      bit_q   <= 4'd0;
      shift_q <= 8'd0;
      left_q  <= 8'd0;
      dev_q   <= 7'd0;
      reg_q   <= 8'd0;
      rmode_q <= 1'b0;
      stat_q  <= irm_pkg::STAT_OK;
      ticks_q <= irm_pkg::PHASE_TICKS_RST;
    end else begin
      if (cfg_we_i) begin
        ticks_q <= cfg_data_i;
      end
      if (take) begin
        phase_q <= phase_d;
        kind_q  <= kind_d;
        qtr_q   <= qtr_d;
        pc_q    <= pc_d;
        bit_q   <= bit_d;
        shift_q <= shift_d;
        left_q  <= left_d;
        dev_q   <= dev_d;
        reg_q   <= reg_d;
        rmode_q <= rmode_d;
        stat_q  <= stat_d;
      end
    end
  end

`ifndef SYNTHESIS
  // bit counter stays within a byte plus ack while shifting
  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BYTE) |-> (bit_q <= 4'd8))
    else $error("bit counter out of range");

  // a byte fetch only follows the register or a data byte
  a_fetch_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FETCH) |-> (kind_q == BK_REG || kind_q == BK_DATA))
    else $error("fetch after wrong byte kind");

  // a byte request parks the sequencer in fetch
  a_req_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && req) |=> (phase_q == PH_FETCH))
    else $error("request without fetch");

  // end of transaction returns to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && done) |=> (phase_q == PH_IDLE))
    else $error("done without idle");
`endif

endmodule

// ----- rtl/core/i2c_register_master_core.sv -----
// channel   | handshake         | payload
// ----------+-------------------+---------------------------
// input     | push / full       | item_i   (irm_pkg::in_item_t)
// result    | pop / empty       | result_o (irm_pkg::out_item_t)
// config    | cfg_we_i          | cfg_data_i (phase ticks)
//
// one result per item; an item is registered in the input queue, and its
// result in the result queue when the sequencer takes it; items may be
// pushed each cycle while full is low; throughput is one item per cycle
// while the result queue has room, set by the sequencer between the queues
// reset clears both queues, the sequencer to idle and phase ticks to 8
// a full result queue stalls the sequencer, which then stops draining the
// input queue; each two-entry queue keeps its side moving for two items
module i2c_register_master_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  irm_pkg::in_item_t  item_i,
  output logic               empty,
  input  logic               pop,
  output irm_pkg::out_item_t result_o,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_data_i
);

  irm_pkg::front_item_t front_item;
  irm_pkg::out_item_t   seq_item;
  logic                 front_valid;
  logic                 seq_take;
  logic                 seq_push;
  logic                 res_ready;

  // front: accept and classify items
  irm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (item_i),
    .valid_o (front_valid),
    .take_i  (seq_take),
    .item_o  (front_item)
  );

  // back: bus sequencer, one tick per item
  irm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (front_valid),
    .in_item_i   (front_item),
    .in_take_o   (seq_take),
    .out_ready_i (res_ready),
    .out_push_o  (seq_push),
    .out_item_o  (seq_item)
  );

  // result queue
  irm_result_q u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (seq_push),
    .ready_o (res_ready),
    .item_i  (seq_item),
    .empty   (empty),
    .pop     (pop),
    .item_o  (result_o)
  );

endmodule
